### hdl/psdc_pkg.sv
// Package: shared types and constants for the path segment drive controller.
`timescale 1ns / 1ps
package psdc_pkg;

   localparam int unsigned DwellTicks = 100;
   localparam int unsigned CordicSteps = 16;

   localparam logic signed [17:0] AngPi = 18'sd25736;
   localparam logic signed [17:0] AngTwoPi = 18'sd51472;
   localparam logic [15:0] MinTurnHeading = 16'd410;
   localparam logic signed [39:0] HalfPiQ16 = 40'sd102944;

   typedef enum logic [1:0] {
      MODE_DRIVE = 2'd0,
      MODE_TURN = 2'd1,
      MODE_DWELL = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_HEADING_GAIN = 3'd0,
      CSR_CROSSTRACK_GAIN = 3'd1,
      CSR_SLOWDOWN_DIST = 3'd2,
      CSR_GOAL_TOL = 3'd3,
      CSR_NO_TURN_DIST = 3'd4,
      CSR_MAX_DRIVE_HEADING = 3'd5,
      CSR_SPEED_LIMIT = 3'd6,
      CSR_TURN_RATE_LIMIT = 3'd7
   } csr_index_type;

   // CORDIC arctangent table, 2^-16 rad units
   function automatic logic [15:0] atan_entry(input logic [3:0] i);
      logic [15:0] v;
      begin
         case (i)
            4'd0: v = 16'd51472;
            4'd1: v = 16'd30385;
            4'd2: v = 16'd16054;
            4'd3: v = 16'd8150;
            4'd4: v = 16'd4091;
            4'd5: v = 16'd2047;
            4'd6: v = 16'd1024;
            4'd7: v = 16'd512;
            4'd8: v = 16'd256;
            4'd9: v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            default: v = 16'd2;
         endcase
         return v;
      end
   endfunction

endpackage

### hdl/path_segment_drive_controller.sv
// Top level: sequenced path segment controller with shared multiply, divide, root, CORDIC.
// One item at a time: the next item is taken only after the result of the last has been accepted.
// Worst case: two 32-step square roots, three 65-step divides, the 16-step CORDIC
// and the turn and speed steps, all on one shared datapath.
// Reset: synchronous active high; registers return to defaults, mode to STOP,
// dwell counter to zero, no result pending.
`timescale 1ns / 1ps
module path_segment_drive_controller
   import psdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [15:0] req_robot_yaw,
   input  logic signed [31:0] req_seg_start_x,
   input  logic signed [31:0] req_seg_start_y,
   input  logic signed [31:0] req_seg_end_x,
   input  logic signed [31:0] req_seg_end_y,
   input  logic               req_tags_present,
   input  logic               req_path_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   output logic [1:0]         rsp_drive_mode,
   output logic               rsp_segment_done,
   output logic               rsp_dwell_expired,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_PDIFF, ST_PSQ0, ST_PSQ1, ST_PSQRT, ST_CROSS0, ST_CROSS1,
      ST_DOT0, ST_DOT1, ST_XDIV, ST_ADIV, ST_GSQ0, ST_GSQ1, ST_GSQRT,
      ST_CPRE, ST_CORDIC, ST_HEAD, ST_MODE, ST_TURN0, ST_TURN1, ST_TURN2,
      ST_SPD0, ST_SPD1, ST_SPDDIV, ST_DONE
   } state_type;

   // configuration
   logic [15:0] heading_gain_ff, crosstrack_gain_ff;
   logic [23:0] slowdown_dist_ff, goal_tol_ff, no_turn_dist_ff;
   logic [14:0] max_drive_heading_ff, speed_limit_ff, turn_rate_limit_ff;

   state_type   state_ff;
   mode_type    mode_ff;
   logic [15:0] dwell_ff;

   // latched item
   logic signed [31:0] rx_ff, ry_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [15:0] yaw_ff;
   logic               tags_ff;

   // work registers
   logic signed [32:0] pdx_ff, pdy_ff, gx_ff, gy_ff;
   logic signed [32:0] rdx_ff, rdy_ff, edx_ff, edy_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] dot_ff;
   logic [31:0]        plen_ff, d_ff;
   logic signed [31:0] xt_ff, at_ff;
   logic [6:0]         cnt_ff;
   // shared sqrt / divide
   logic [63:0]        rem_ff;
   logic [63:0]        quo_ff;
   logic [64:0]        num_ff;
   logic [32:0]        den_ff;
   logic               neg_ff;
   // cordic
   logic signed [39:0] cx_ff, cy_ff, cz_ff;
   logic signed [17:0] he_ff;
   logic               timeout_ff;

   logic               rsp_valid_ff;
   logic [14:0]        lin_ff;
   logic signed [15:0] ang_ff;
   logic [1:0]         omode_ff;
   logic               done_ff;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_linear_cmd = lin_ff;
   assign rsp_angular_cmd = ang_ff;
   assign rsp_drive_mode = omode_ff;
   assign rsp_segment_done = done_ff;
   assign rsp_dwell_expired = timeout_ff;

   // saturating difference to +-(2^31-1)
   function automatic logic signed [32:0] sdiff(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [32:0] d;
      begin
         d = 33'(a) - 33'(b);
         if (d > 33'sd2147483647) d = 33'sd2147483647;
         else if (d < -33'sd2147483647) d = -33'sd2147483647;
         return d;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      begin
         if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
         else if (v < -66'sd2147483648) return 32'sh80000000;
         else return v[31:0];
      end
   endfunction

   // one shared signed multiplier, 33x33
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // sqrt step (restoring, digit pair) and divide step
   logic [63:0] sq_trial;
   logic [65:0] sq_rem2;
   logic [64:0] dv_rem;
   logic        dv_ge;
   logic [63:0] dv_quo;
   assign sq_rem2 = {rem_ff, num_ff[63:62]};
   assign sq_trial = {quo_ff[61:0], 2'b01};
   assign dv_rem = {rem_ff[63:0], num_ff[64]};
   assign dv_ge = dv_rem >= 65'(den_ff);
   assign dv_quo = {quo_ff[62:0], dv_ge};

   // cordic shifted terms, rounding offset added on the last step
   logic signed [39:0] cxs, cys, cz_bias;
   assign cxs = cx_ff >>> cnt_ff[3:0];
   assign cys = cy_ff >>> cnt_ff[3:0];
   assign cz_bias = (cnt_ff == 7'(CordicSteps - 1)) ? 40'sd4 : 40'sd0;

   // heading / mode helpers
   logic [17:0] he_abs;
   logic signed [17:0] he_raw;
   assign he_abs = he_ff[17] ? 18'(-he_ff) : 18'(he_ff);
   assign he_raw = 18'(cz_ff >>> 3) - 18'(yaw_ff);

   // signed along-track compares
   logic signed [33:0] at2, gtol3, sdist_s;
   assign at2 = 34'sd2 * 34'(at_ff);
   assign gtol3 = 34'sd3 * 34'($signed({1'b0, goal_tol_ff}));
   assign sdist_s = 34'($signed({1'b0, sdist}));

   // turn command rounding and clamp
   logic signed [65:0] turn_w, turn_lim;
   assign turn_w = (acc_ff + 66'sd32768) >>> 16;
   assign turn_lim = 66'($signed({1'b0, turn_rate_limit_ff}));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PSQ0: begin mul_a = pdx_ff; mul_b = pdx_ff; end
         ST_PSQ1: begin mul_a = pdy_ff; mul_b = pdy_ff; end
         ST_CROSS0: begin mul_a = rdx_ff; mul_b = pdy_ff; end
         ST_CROSS1: begin mul_a = rdy_ff; mul_b = pdx_ff; end
         ST_DOT0: begin mul_a = edx_ff; mul_b = -pdx_ff; end
         ST_DOT1: begin mul_a = edy_ff; mul_b = -pdy_ff; end
         ST_GSQ0: begin mul_a = gx_ff; mul_b = gx_ff; end
         ST_GSQ1: begin mul_a = gy_ff; mul_b = gy_ff; end
         ST_TURN0: begin mul_a = 33'(he_ff); mul_b = 33'({heading_gain_ff, 3'b000}); end
         ST_TURN1: begin mul_a = 33'({1'b0, crosstrack_gain_ff}); mul_b = 33'(xt_ff); end
         ST_SPD1: begin mul_a = 33'(num_ff[23:0]); mul_b = 33'(speed_limit_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   logic [23:0] sdist;
   assign sdist = (slowdown_dist_ff == '0) ? 24'd1 : slowdown_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_gain_ff <= 16'd6144;
         crosstrack_gain_ff <= 16'd2048;
         slowdown_dist_ff <= 24'd16384;
         goal_tol_ff <= 24'd655;
         no_turn_dist_ff <= 24'd16384;
         max_drive_heading_ff <= 15'd4096;
         speed_limit_ff <= 15'd2458;
         turn_rate_limit_ff <= 15'd6431;
         state_ff <= ST_IDLE;
         mode_ff <= MODE_STOP;
         dwell_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_HEADING_GAIN: heading_gain_ff <= csr_data[15:0];
               CSR_CROSSTRACK_GAIN: crosstrack_gain_ff <= csr_data[15:0];
               CSR_SLOWDOWN_DIST: slowdown_dist_ff <= csr_data[23:0];
               CSR_GOAL_TOL: goal_tol_ff <= csr_data[23:0];
               CSR_NO_TURN_DIST: no_turn_dist_ff <= csr_data[23:0];
               CSR_MAX_DRIVE_HEADING: max_drive_heading_ff <= csr_data[14:0];
               CSR_SPEED_LIMIT: speed_limit_ff <= csr_data[14:0];
               default: turn_rate_limit_ff <= csr_data[14:0];
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  rx_ff <= req_robot_x; ry_ff <= req_robot_y;
                  sx_ff <= req_seg_start_x; sy_ff <= req_seg_start_y;
                  ex_ff <= req_seg_end_x; ey_ff <= req_seg_end_y;
                  yaw_ff <= req_robot_yaw;
                  tags_ff <= req_tags_present;
                  if (req_path_start) dwell_ff <= '0;
                  state_ff <= ST_PDIFF;
               end
            end
            ST_PDIFF: begin
               pdx_ff <= sdiff(ex_ff, sx_ff); pdy_ff <= sdiff(ey_ff, sy_ff);
               rdx_ff <= sdiff(rx_ff, sx_ff); rdy_ff <= sdiff(ry_ff, sy_ff);
               edx_ff <= sdiff(rx_ff, ex_ff); edy_ff <= sdiff(ry_ff, ey_ff);
               gx_ff <= sdiff(ex_ff, rx_ff); gy_ff <= sdiff(ey_ff, ry_ff);
               state_ff <= ST_PSQ0;
            end
            ST_PSQ0, ST_GSQ0: begin
               acc_ff <= mul_p;
               state_ff <= (state_ff == ST_PSQ0) ? ST_PSQ1 : ST_GSQ1;
            end
            ST_PSQ1, ST_GSQ1: begin
               num_ff <= 65'(acc_ff[63:0] + mul_p[63:0]);
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
               state_ff <= (state_ff == ST_PSQ1) ? ST_PSQRT : ST_GSQRT;
            end
            ST_PSQRT, ST_GSQRT: begin
               // one result bit per cycle
               if (sq_rem2 >= 66'(sq_trial)) begin
                  rem_ff <= 64'(sq_rem2 - 66'(sq_trial));
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= sq_rem2[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
               num_ff <= {num_ff[62:0], 2'b00};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) begin
                  if (state_ff == ST_PSQRT) state_ff <= ST_CROSS0;
                  else state_ff <= ST_CPRE;
               end
            end
            ST_CROSS0: begin
               plen_ff <= quo_ff[31:0];
               acc_ff <= mul_p;
               state_ff <= ST_CROSS1;
            end
            ST_CROSS1: begin
               acc_ff <= acc_ff - mul_p;
               state_ff <= ST_DOT0;
            end
            ST_DOT0: begin
               dot_ff <= mul_p;
               state_ff <= ST_DOT1;
            end
            ST_DOT1: begin
               dot_ff <= dot_ff + mul_p;
               if (plen_ff == '0) begin
                  xt_ff <= '0; at_ff <= '0;
                  state_ff <= ST_GSQ0;
               end else begin
                  neg_ff <= acc_ff[65];
                  num_ff <= 65'(acc_ff[65] ? -acc_ff : acc_ff);
                  den_ff <= 33'(plen_ff);
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
                  state_ff <= ST_XDIV;
               end
            end
            ST_XDIV, ST_ADIV, ST_SPDDIV: begin
               // restoring divide, one quotient bit per cycle; last bit taken with the result
               if (cnt_ff != 7'd64) begin
                  if (dv_ge) rem_ff <= 64'(dv_rem - 65'(den_ff));
                  else rem_ff <= dv_rem[63:0];
                  quo_ff <= dv_quo;
                  num_ff <= {num_ff[63:0], 1'b0};
                  cnt_ff <= cnt_ff + 7'd1;
               end else if (state_ff == ST_XDIV) begin
                  xt_ff <= sat32(neg_ff ? -66'(dv_quo) : 66'(dv_quo));
                  neg_ff <= dot_ff[65];
                  num_ff <= 65'(dot_ff[65] ? -dot_ff : dot_ff);
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
                  state_ff <= ST_ADIV;
               end else if (state_ff == ST_ADIV) begin
                  at_ff <= sat32(neg_ff ? -66'(dv_quo) : 66'(dv_quo));
                  state_ff <= ST_GSQ0;
               end else begin
                  lin_ff <= (dv_quo > 64'd32767) ? 15'h7FFF : dv_quo[14:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_CPRE: begin
               d_ff <= quo_ff[31:0];
               cnt_ff <= '0;
               if (gx_ff == '0 && gy_ff == '0) begin
                  cz_ff <= '0;
                  state_ff <= ST_HEAD;
               end else if (gx_ff[32]) begin
                  if (!gy_ff[32]) begin
                     cx_ff <= 40'(gy_ff); cy_ff <= -40'(gx_ff); cz_ff <= HalfPiQ16;
                  end else begin
                     cx_ff <= -40'(gy_ff); cy_ff <= 40'(gx_ff); cz_ff <= -HalfPiQ16;
                  end
                  state_ff <= ST_CORDIC;
               end else begin
                  cx_ff <= 40'(gx_ff); cy_ff <= 40'(gy_ff); cz_ff <= '0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + cys; cy_ff <= cy_ff - cxs;
                  cz_ff <= cz_ff + 40'(atan_entry(cnt_ff[3:0])) + cz_bias;
               end else begin
                  cx_ff <= cx_ff - cys; cy_ff <= cy_ff + cxs;
                  cz_ff <= cz_ff - 40'(atan_entry(cnt_ff[3:0])) + cz_bias;
               end
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(CordicSteps - 1)) state_ff <= ST_HEAD;
            end
            ST_HEAD: begin
               // wrap to (-pi, pi]
               if (he_raw > AngPi) he_ff <= he_raw - AngTwoPi;
               else if (he_raw <= -AngPi) he_ff <= he_raw + AngTwoPi;
               else he_ff <= he_raw;
               state_ff <= ST_MODE;
            end
            ST_MODE: begin
               timeout_ff <= 1'b0;
               lin_ff <= '0; ang_ff <= '0; done_ff <= 1'b0;
               if (he_abs >= 18'(max_drive_heading_ff) && d_ff > 32'(no_turn_dist_ff) &&
                   (mode_ff == MODE_DRIVE || mode_ff == MODE_DWELL)) begin
                  mode_ff <= MODE_TURN;
                  state_ff <= ST_TURN0;
               end else if (he_abs >= 18'(MinTurnHeading) && mode_ff == MODE_TURN) begin
                  state_ff <= ST_TURN0;
               end else if ((mode_ff == MODE_TURN) ||
                            (at2 < -gtol3 && mode_ff == MODE_DRIVE && !tags_ff)) begin
                  dwell_ff <= '0;
                  mode_ff <= MODE_DWELL;
                  state_ff <= ST_DONE;
               end else if (mode_ff == MODE_DWELL && !tags_ff) begin
                  if (dwell_ff >= 16'(DwellTicks)) timeout_ff <= 1'b1;
                  else dwell_ff <= dwell_ff + 16'd1;
                  state_ff <= ST_DONE;
               end else begin
                  mode_ff <= MODE_DRIVE;
                  if (d_ff < 32'(goal_tol_ff) && tags_ff) begin
                     done_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (d_ff > 32'(no_turn_dist_ff)) begin
                     state_ff <= ST_TURN0;
                  end else begin
                     state_ff <= ST_SPD0;
                  end
               end
            end
            ST_TURN0: begin
               acc_ff <= mul_p;
               state_ff <= (mode_ff == MODE_DRIVE) ? ST_TURN1 : ST_TURN2;
            end
            ST_TURN1: begin
               acc_ff <= acc_ff + mul_p;
               state_ff <= ST_TURN2;
            end
            ST_TURN2: begin
               // round half up to Q4.12, clamp
               if (turn_w > turn_lim) ang_ff <= 16'(turn_rate_limit_ff);
               else if (turn_w < -turn_lim) ang_ff <= -16'(turn_rate_limit_ff);
               else ang_ff <= turn_w[15:0];
               state_ff <= (mode_ff == MODE_DRIVE) ? ST_SPD0 : ST_DONE;
            end
            ST_SPD0: begin
               if (at2 <= gtol3) begin
                  num_ff <= 65'(goal_tol_ff);
                  state_ff <= ST_SPD1;
               end else if (34'(at_ff) <= sdist_s) begin
                  num_ff <= tags_ff ? 65'(goal_tol_ff) : 65'(at_ff[23:0]);
                  state_ff <= ST_SPD1;
               end else begin
                  lin_ff <= speed_limit_ff;
                  state_ff <= ST_DONE;
               end
            end
            ST_SPD1: begin
               num_ff <= 65'(mul_p[63:0]);
               den_ff <= 33'(sdist);
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
               state_ff <= ST_SPDDIV;
            end
            ST_DONE: begin
               omode_ff <= mode_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### tb/tb_path_segment_drive_controller.sv
// Testbench for the path segment drive controller: random stimulus, tick predictor, checker.
`timescale 1ns / 1ps
module tb_path_segment_drive_controller;
   import psdc_pkg::*;

   localparam longint DiffMax = 64'sd2147483647;
   localparam longint QuietLimit = 20000;
   localparam int SettleCycles = 400;
   localparam longint ArcTab [16] = '{51472, 30385, 16054, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      logic signed [31:0] rx, ry, sx, sy, ex, ey;
      logic signed [15:0] yaw;
      logic               tags, start;
   } tick_t;

   typedef struct {
      logic [14:0]        linear;
      logic signed [15:0] angular;
      mode_type           mode;
      logic               done, timeout;
   } cmd_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_robot_x = '0, req_robot_y = '0;
   logic signed [15:0] req_robot_yaw = '0;
   logic signed [31:0] req_seg_start_x = '0, req_seg_start_y = '0;
   logic signed [31:0] req_seg_end_x = '0, req_seg_end_y = '0;
   logic               req_tags_present = 1'b0, req_path_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [14:0]        rsp_linear_cmd;
   logic signed [15:0] rsp_angular_cmd;
   logic [1:0]         rsp_drive_mode;
   logic               rsp_segment_done, rsp_dwell_expired;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   tick_t pending_ticks[$];
   cmd_t  expected_cmds[$];
   longint unsigned gain_hd, gain_xt, slow_dist, goal_tol, no_turn, max_head, spd_lim, turn_lim;
   mode_type        ctl_mode;
   longint unsigned dwell_cnt;
   int              errors = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   longint          quiet = 0;
   bit              no_gaps = 1'b0;

   path_segment_drive_controller dut (.*);

   always #4 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint clip_diff(longint a, longint b);
      longint d;
      d = a - b;
      if (d > DiffMax) return DiffMax;
      if (d < -DiffMax) return -DiffMax;
      return d;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned span(longint x, longint y);
      return root_floor(longint'(unsigned'(x * x)) + longint'(unsigned'(y * y)));
   endfunction

   // CORDIC vectoring, result rounded to Q3.13
   function automatic longint bearing(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 102944;
         end else begin
            t = x; x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ArcTab[i];
         end else begin
            x -= ys; y += xs; z -= ArcTab[i];
         end
      end
      return (z + 4) >>> 3;
   endfunction

   function automatic longint unsigned speed_cmd(longint at, bit tags);
      longint unsigned s, num, v;
      s = (slow_dist != 0) ? slow_dist : 1;
      if (2 * at <= 3 * longint'(goal_tol)) num = goal_tol;
      else if (at <= longint'(s)) num = tags ? goal_tol : longint'(unsigned'(at));
      else return spd_lim;
      v = num * spd_lim / s;
      return (v > 32767) ? 32767 : v;
   endfunction

   function automatic longint turn_cmd(longint acc);
      longint w;
      w = (acc + 32768) >>> 16;
      if (w > longint'(turn_lim)) w = turn_lim;
      if (w < -longint'(turn_lim)) w = -longint'(turn_lim);
      return w;
   endfunction

   function automatic cmd_t control_tick(tick_t t);
      longint pdx, pdy, rdx, rdy, edx, edy, xt, at, gx, gy, he, he_abs, ang;
      longint unsigned plen, d, lin;
      cmd_t c;
      xt = 0; at = 0; ang = 0; lin = 0;
      c.done = 1'b0;
      c.timeout = 1'b0;
      if (t.start) dwell_cnt = 0;
      // segment geometry
      pdx = clip_diff(t.ex, t.sx);
      pdy = clip_diff(t.ey, t.sy);
      plen = span(pdx, pdy);
      if (plen > 0) begin
         rdx = clip_diff(t.rx, t.sx);
         rdy = clip_diff(t.ry, t.sy);
         edx = clip_diff(t.rx, t.ex);
         edy = clip_diff(t.ry, t.ey);
         xt = clip32((rdx * pdy - rdy * pdx) / longint'(plen));
         at = clip32((edx * (-pdx) + edy * (-pdy)) / longint'(plen));
      end
      gx = clip_diff(t.ex, t.rx);
      gy = clip_diff(t.ey, t.ry);
      d = span(gx, gy);
      he = bearing(gy, gx) - longint'(t.yaw);
      while (he > 25736) he -= 51472;
      while (he <= -25736) he += 51472;
      he_abs = (he < 0) ? -he : he;
      // mode machine
      if (he_abs >= longint'(max_head) && d > no_turn &&
          (ctl_mode == MODE_DRIVE || ctl_mode == MODE_DWELL)) begin
         ctl_mode = MODE_TURN;
      end else if (he_abs >= 410 && ctl_mode == MODE_TURN) begin
         ctl_mode = MODE_TURN;
      end else if ((he_abs < 410 && ctl_mode == MODE_TURN) ||
                   (2 * at < -3 * longint'(goal_tol) && ctl_mode == MODE_DRIVE && !t.tags)) begin
         dwell_cnt = 0;
         ctl_mode = MODE_DWELL;
      end else if (ctl_mode == MODE_DWELL && !t.tags) begin
         if (dwell_cnt >= DwellTicks) c.timeout = 1'b1;
         else dwell_cnt++;
      end else begin
         ctl_mode = MODE_DRIVE;
      end
      // commands
      if (!c.timeout) begin
         if (ctl_mode == MODE_DRIVE) begin
            if (d < goal_tol && t.tags) begin
               c.done = 1'b1;
            end else begin
               lin = speed_cmd(at, t.tags);
               if (d > no_turn)
                  ang = turn_cmd(he * longint'(gain_hd) * 8 + longint'(gain_xt) * xt);
            end
         end else if (ctl_mode == MODE_TURN) begin
            ang = turn_cmd(he * longint'(gain_hd) * 8);
         end
      end
      c.linear = lin[14:0];
      c.angular = ang[15:0];
      c.mode = ctl_mode;
      return c;
   endfunction

   function automatic void load_setting(csr_index_type idx, longint unsigned v);
      case (idx)
         CSR_HEADING_GAIN:      gain_hd = v & 16'hFFFF;
         CSR_CROSSTRACK_GAIN:   gain_xt = v & 16'hFFFF;
         CSR_SLOWDOWN_DIST:     slow_dist = v & 24'hFFFFFF;
         CSR_GOAL_TOL:          goal_tol = v & 24'hFFFFFF;
         CSR_NO_TURN_DIST:      no_turn = v & 24'hFFFFFF;
         CSR_MAX_DRIVE_HEADING: max_head = v & 15'h7FFF;
         CSR_SPEED_LIMIT:       spd_lim = v & 15'h7FFF;
         default:               turn_lim = v & 15'h7FFF;
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [15:0] wrap_yaw(longint a);
      while (a > 25736) a -= 51472;
      while (a < -25736) a += 51472;
      return a[15:0];
   endfunction

   function automatic tick_t noise_tick();
      tick_t t;
      t.rx = $urandom; t.ry = $urandom; t.sx = $urandom; t.sy = $urandom;
      t.ex = $urandom; t.ey = $urandom;
      t.yaw = 16'($urandom_range(0, 51472) - 25736);
      t.tags = 1'($urandom_range(0, 1));
      t.start = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // robot near a short segment, yaw mostly close to the bearing of the segment end
   function automatic tick_t path_tick();
      tick_t t;
      longint f, sx, sy, ex, ey;
      sx = longint'($urandom_range(0, 1310720)) - 655360;
      sy = longint'($urandom_range(0, 1310720)) - 655360;
      ex = sx + longint'($urandom_range(0, 655360)) - 327680;
      ey = sy + longint'($urandom_range(0, 655360)) - 327680;
      f = longint'($urandom_range(0, 340)) - 40;
      t.sx = 32'(sx); t.sy = 32'(sy); t.ex = 32'(ex); t.ey = 32'(ey);
      t.rx = 32'(sx + (ex - sx) * f / 256 + longint'($urandom_range(0, 40000)) - 20000);
      t.ry = 32'(sy + (ey - sy) * f / 256 + longint'($urandom_range(0, 40000)) - 20000);
      if ($urandom_range(0, 3) == 0)
         t.yaw = 16'($urandom_range(0, 51472) - 25736);
      else
         t.yaw = wrap_yaw(bearing(longint'(t.ey) - t.ry, longint'(t.ex) - t.rx) +
                          longint'($urandom_range(0, 1200)) - 600);
      t.tags = ($urandom_range(0, 9) < 7);
      t.start = ($urandom_range(0, 19) == 0);
      return t;
   endfunction

   // robot just past the end of an axis-aligned segment with no tags: holds dwell
   function automatic tick_t overshoot_tick(logic signed [31:0] sx, logic signed [31:0] sy,
                                            bit first);
      tick_t t;
      t.sx = sx; t.sy = sy;
      t.ex = sx + 32'sd131072; t.ey = sy;
      t.rx = t.ex + 32'sd6554; t.ry = sy;
      t.yaw = 16'sd25736;
      t.tags = 1'b0;
      t.start = first;
      return t;
   endfunction

   task automatic queue_mix(int n);
      tick_t t;
      for (int i = 0; i < n; i++) begin
         t = ($urandom_range(0, 9) == 0) ? noise_tick() : path_tick();
         pending_ticks = {pending_ticks, t};
      end
   endtask

   task automatic settle();
      while (pending_ticks.size() != 0 || req_valid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // valid stays high across a burst; the caller drops it
   task automatic write_setting(csr_index_type idx, longint unsigned v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v[31:0];
      do @(posedge clock); while (!csr_ready);
      load_setting(idx, v);
   endtask

   task automatic write_all(longint unsigned v[8]);
      for (int i = 0; i < 8; i++) write_setting(csr_index_type'(i), v[i]);
      csr_valid <= 1'b0;
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_cmds = {expected_cmds, control_tick('{req_robot_x, req_robot_y,
               req_seg_start_x, req_seg_start_y, req_seg_end_x, req_seg_end_y, req_robot_yaw,
               req_tags_present, req_path_start})};
         end
         if (!req_valid || !req_stall) begin
            if (req_valid) gap_left = pick_gap();
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               tick_t t;
               t = pending_ticks.pop_front();
               req_robot_x <= t.rx; req_robot_y <= t.ry; req_robot_yaw <= t.yaw;
               req_seg_start_x <= t.sx; req_seg_start_y <= t.sy;
               req_seg_end_x <= t.ex; req_seg_end_y <= t.ey;
               req_tags_present <= t.tags; req_path_start <= t.start;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected result linear=%0d angular=%0d mode=%0d",
                        $time, rsp_linear_cmd, rsp_angular_cmd, rsp_drive_mode);
               errors++;
            end else begin
               cmd_t e;
               e = expected_cmds.pop_front();
               if (rsp_linear_cmd !== e.linear) begin
                  $display("%0t: linear_cmd expected %0d actual %0d", $time, e.linear,
                           rsp_linear_cmd);
                  errors++;
               end
               if (rsp_angular_cmd !== e.angular) begin
                  $display("%0t: angular_cmd expected %0d actual %0d", $time, e.angular,
                           rsp_angular_cmd);
                  errors++;
               end
               if (rsp_drive_mode !== e.mode) begin
                  $display("%0t: drive_mode expected %0d actual %0d", $time, e.mode,
                           rsp_drive_mode);
                  errors++;
               end
               if (rsp_segment_done !== e.done) begin
                  $display("%0t: segment_done expected %0d actual %0d", $time, e.done,
                           rsp_segment_done);
                  errors++;
               end
               if (rsp_dwell_expired !== e.timeout) begin
                  $display("%0t: dwell_expired expected %0d actual %0d", $time, e.timeout,
                           rsp_dwell_expired);
                  errors++;
               end
            end
         end
         // stall runs of random length on the result side
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
         $display("path_segment_drive_controller test failed");
         $finish;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      tick_t t;
      longint unsigned v[8];
      gain_hd = 6144; gain_xt = 2048; slow_dist = 16384; goal_tol = 655;
      no_turn = 16384; max_head = 4096; spd_lim = 2458; turn_lim = 6431;
      ctl_mode = MODE_STOP;
      dwell_cnt = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero-length segment, robot on the end point, segment reached
      t = '{32'sd100000, 32'sd5000, 32'sd0, 32'sd0, 32'sd200000, 32'sd0, 16'sd0, 1'b1, 1'b1};
      pending_ticks = {pending_ticks, t};
      t.rx = 32'sd200000; t.ry = 32'sd0;
      pending_ticks = {pending_ticks, t};
      t.tags = 1'b0;
      pending_ticks = {pending_ticks, t};
      t = '{32'sd7, 32'sd9, 32'sd300, 32'sd300, 32'sd300, 32'sd300, 16'sd25736, 1'b0, 1'b0};
      pending_ticks = {pending_ticks, t};
      t.rx = 32'sd300; t.ry = 32'sd300; t.yaw = -16'sd25736;
      pending_ticks = {pending_ticks, t};
      t = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 16'sd25736, 1'b1, 1'b0};
      pending_ticks = {pending_ticks, t};
      t = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
            32'h7FFFFFFF, -16'sd25736, 1'b0, 1'b1};
      pending_ticks = {pending_ticks, t};
      t = '{32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
            16'sd0, 1'b1, 1'b1};
      pending_ticks = {pending_ticks, t};
      t = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd131072, 32'sd0, 16'sd0, 1'b0, 1'b0};
      pending_ticks = {pending_ticks, t};
      pending_ticks = {pending_ticks, t};
      t.yaw = 16'sd25736;
      pending_ticks = {pending_ticks, t};
      for (int i = 0; i < 8; i++) begin
         t = path_tick();
         pending_ticks = {pending_ticks, t};
      end
      settle();

      // long dwell: runs into the timeout, then path_start clears it
      for (int i = 0; i < 110; i++) begin
         t = overshoot_tick(32'sd65536, -32'sd65536, i == 0);
         pending_ticks = {pending_ticks, t};
      end
      for (int i = 0; i < 4; i++) begin
         t = overshoot_tick(32'sd65536, -32'sd65536, i == 1);
         pending_ticks = {pending_ticks, t};
      end
      queue_mix(30);
      settle();

      // random settings
      v = '{$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 200000),
            $urandom_range(0, 20000), $urandom_range(0, 40000), $urandom_range(0, 25736),
            $urandom_range(0, 32767), $urandom_range(0, 32767)};
      write_all(v);
      no_gaps = 1'b1;
      queue_mix(40);
      settle();
      no_gaps = 1'b0;
      queue_mix(40);
      settle();

      // upper extremes
      v = '{65535, 65535, 16777215, 16777215, 16777215, 25736, 32767, 32767};
      write_all(v);
      queue_mix(45);
      settle();

      // lower extremes
      v = '{0, 0, 1, 0, 0, 0, 0, 0};
      write_all(v);
      queue_mix(45);
      settle();

      // mid settings, long dwell again with random traffic after it
      v = '{$urandom_range(2000, 20000), $urandom_range(0, 8000), $urandom_range(1, 65536),
            $urandom_range(0, 2000), $urandom_range(8000, 30000), $urandom_range(410, 8000),
            $urandom_range(0, 32767), $urandom_range(1000, 32767)};
      write_all(v);
      for (int i = 0; i < 105; i++) begin
         t = overshoot_tick(-32'sd40000, 32'sd90000, i == 0);
         pending_ticks = {pending_ticks, t};
      end
      queue_mix(30);
      settle();

      if (errors == 0)
         $display("path_segment_drive_controller test passed");
      else
         $display("path_segment_drive_controller test failed");
      $finish;
   end

endmodule

### sim.f
hdl/psdc_pkg.sv
hdl/path_segment_drive_controller.sv
tb/tb_path_segment_drive_controller.sv
